// File: sv/pivoted_lu_linear_solver_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef PIVOTED_LU_LINEAR_SOLVER_MACROS_SVH
`define PIVOTED_LU_LINEAR_SOLVER_MACROS_SVH

// Same-cycle implication.
`define PLU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pivoted LU solver: assertion failed");

// Next-cycle implication.
`define PLU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pivoted LU solver: assertion failed");

`endif

// File: sv/plu_pkg.sv
// ----------------------------------------------------------------------------
// plu_pkg
// Shared constants, controller states, datapath command and status types.
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int DIM_DEF = 8;
    localparam int MAX_DIM = 32;
    localparam int CNT_W   = 6;   // holds 0..MAX_DIM
    localparam int DATA_W  = 32;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_PV_FIRST,
        DP_PV_FIRSTW,
        DP_PV_RD,
        DP_PV_CMP,
        DP_PV_END,
        DP_Z_WR,
        DP_E_RD,
        DP_E_DIV,
        DP_E_WM,
        DP_K_RD,
        DP_K_MUL,
        DP_K_WR,
        DP_F_INIT,
        DP_S_RD,
        DP_S_MUL,
        DP_S_ACC,
        DP_F_WR,
        DP_B_INIT,
        DP_B_DIAG,
        DP_B_DIV,
        DP_B_WR,
        DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_PV_FIRST,
        S_PV_FIRSTW,
        S_PV_RD,
        S_PV_CMP,
        S_PV_END,
        S_Z_WR,
        S_E_RD,
        S_E_DIV,
        S_E_WAIT,
        S_K_RD,
        S_K_MUL,
        S_K_WR,
        S_E_WM,
        S_F_INIT,
        S_F_RD,
        S_F_MUL,
        S_F_ACC,
        S_F_WR,
        S_B_INIT,
        S_B_RD,
        S_B_MUL,
        S_B_ACC,
        S_B_DIAG,
        S_B_DIV,
        S_B_WAIT,
        S_OUT,
        S_OUT_WAIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] i;
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic piv_zero;
        logic out_full;
    } dp_sts_t;

endpackage

// File: sv/plu_if.sv
// ----------------------------------------------------------------------------
// plu_if
// Request channels: load items in, solution elements out.
// ----------------------------------------------------------------------------
interface plu_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               start_req;

    modport source (output valid, operation, row, col, value, start_req, input ready);
    modport sink   (input valid, operation, row, col, value, start_req, output ready);
endinterface

interface plu_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         index;
    logic signed [31:0] solution;
    logic               final_res;
    logic               zero_pivot;

    modport source (output valid, index, solution, final_res, zero_pivot, input ready);
    modport sink   (input valid, index, solution, final_res, zero_pivot, output ready);
endinterface

// File: sv/plu_div.sv
// ----------------------------------------------------------------------------
// plu_div
// Iterative Q15.16 divider: sat((num * 2^16) / den), truncated toward zero,
// one quotient bit per cycle. A zero divisor gives zero at once.
// ----------------------------------------------------------------------------
module plu_div
    import plu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     busy,
    output logic signed [DATA_W-1:0] quo
);

    localparam int QW = DATA_W + 16;

    logic              busy_reg;
    logic [5:0]        cnt_reg;
    logic [QW-1:0]     dvd_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dmag_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [DATA_W:0]   trial;
    logic              fits;
    logic [DATA_W-1:0] nmag;
    logic [DATA_W-1:0] dmag;

    // Magnitudes of the operands and the trial subtraction
    always_comb
    begin
        nmag  = num[DATA_W-1] ? (~num + 1'b1) : num;
        dmag  = den[DATA_W-1] ? (~den + 1'b1) : den;
        trial = {rem_reg, dvd_reg[QW-1]};
        fits  = trial >= {1'b0, dmag_reg};
    end

    // Shift-subtract step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (den != '0);
            cnt_reg  <= 6'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {nmag, 16'd0};
            rem_reg  <= '0;
            dmag_reg <= dmag;
            neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DATA_W'(trial - {1'b0, dmag_reg}) : trial[DATA_W-1:0];
            dvd_reg <= {dvd_reg[QW-2:0], fits};
        end
    end

    // Sign and saturation of the quotient
    always_comb
    begin
        if (zero_reg)
        begin
            quo = '0;
        end
        else if (neg_reg)
        begin
            if (dvd_reg > QW'(33'h080000000))
            begin
                quo = 32'sh80000000;
            end
            else
            begin
                quo = -$signed(dvd_reg[DATA_W-1:0]);
            end
        end
        else
        begin
            if (dvd_reg > QW'(32'h7fffffff))
            begin
                quo = 32'sh7fffffff;
            end
            else
            begin
                quo = $signed(dvd_reg[DATA_W-1:0]);
            end
        end
    end

    assign busy = busy_reg;

endmodule

// File: sv/plu_dpath.sv
// ----------------------------------------------------------------------------
// plu_dpath
// Datapath: matrix memory, row order, right-hand side, work vector, one
// multiplier, the shared divider and the output register.
// ----------------------------------------------------------------------------
module plu_dpath
    import plu_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic               operation,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [31:0] value,
    plu_result_if.source       out_ch
);

    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = $clog2(DIM * DIM);

    logic signed [DATA_W-1:0] matrix_mem [DIM*DIM];
    logic [IW-1:0]            ro_reg [DIM];
    logic signed [DATA_W-1:0] rhs_reg [DIM];
    logic signed [DATA_W-1:0] wv_reg [DIM];

    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] cur_val_reg;
    logic [IW-1:0]            cur_piv_reg;
    logic [IW-1:0]            pj_reg;
    logic [IW-1:0]            pi_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [63:0]       prod_reg;
    logic                     err_reg;
    logic                     out_valid_reg;
    logic [2:0]               out_index_reg;
    logic signed [DATA_W-1:0] out_sol_reg;
    logic                     out_final_reg;
    logic                     out_zero_reg;

    logic [IW-1:0]            ci, cj, ck;
    logic [IW-1:0]            ro_addr;
    logic [IW-1:0]            ro_sel;
    logic [IW-1:0]            wv_addr;
    logic signed [DATA_W-1:0] wv_sel;
    logic [AW-1:0]            raddr;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [63:0]       prod_next;
    logic signed [DATA_W-1:0] prod_rnd;
    logic                     div_start;
    logic signed [DATA_W-1:0] div_num, div_den;
    logic                     div_busy;
    logic signed [DATA_W-1:0] div_quo;
    logic                     row_ok, col_ok;

    function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        maddr = AW'(AW'(r) * AW'(DIM) + AW'(c));
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Round half up to Q15.16 and saturate
    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647)
        begin
            rnd_sat = 32'sh7fffffff;
        end
        else if (t < -64'sd2147483648)
        begin
            rnd_sat = 32'sh80000000;
        end
        else
        begin
            rnd_sat = t[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
        begin
            sub_sat = d[DATA_W] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            sub_sat = d[DATA_W-1:0];
        end
    endfunction

    assign ci = cmd.i[IW-1:0];
    assign cj = cmd.j[IW-1:0];
    assign ck = cmd.k[IW-1:0];

    assign row_ok = 32'(row) < DIM;
    assign col_ok = 32'(col) < DIM;

    // Single read selects on row order and work vector
    always_comb
    begin
        ro_addr = cj;
        wv_addr = cj;
        case (cmd.op)
            DP_PV_FIRST, DP_F_INIT, DP_B_INIT:
            begin
                ro_addr = ci;
            end
            default:
            begin
                ro_addr = cj;
            end
        endcase
        case (cmd.op)
            DP_B_INIT, DP_OUT:
            begin
                wv_addr = ci;
            end
            default:
            begin
                wv_addr = cj;
            end
        endcase
    end

    assign ro_sel = ro_reg[ro_addr];
    assign wv_sel = wv_reg[wv_addr];
    assign prod_rnd = rnd_sat(prod_reg);

    // Memory address, write port, multiplier and divider operands
    always_comb
    begin
        raddr     = '0;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        mul_a     = rdata_reg;
        mul_b     = wv_sel;
        div_start = 1'b0;
        div_num   = rdata_reg;
        div_den   = cur_val_reg;
        unique case (cmd.op)
            DP_LOAD:
            begin
                we    = (operation == 1'b0) && row_ok && col_ok;
                waddr = maddr(IW'(row), IW'(col));
                wdata = value;
            end
            DP_PV_FIRST, DP_PV_RD, DP_E_RD:
            begin
                raddr = maddr(ro_sel, ci);
            end
            DP_Z_WR:
            begin
                we    = 1'b1;
                waddr = maddr(ro_sel, ci);
            end
            DP_E_DIV:
            begin
                div_start = 1'b1;
            end
            DP_E_WM:
            begin
                we    = 1'b1;
                waddr = maddr(pj_reg, ci);
                wdata = div_quo;
            end
            DP_K_RD:
            begin
                raddr = maddr(cur_piv_reg, ck);
            end
            DP_K_MUL:
            begin
                raddr = maddr(pj_reg, ck);
                mul_a = div_quo;
                mul_b = rdata_reg;
            end
            DP_K_WR:
            begin
                we    = 1'b1;
                waddr = maddr(pj_reg, ck);
                wdata = sub_sat(rdata_reg, prod_rnd);
            end
            DP_S_RD:
            begin
                raddr = maddr(pi_reg, cj);
            end
            DP_B_DIAG:
            begin
                raddr = maddr(pi_reg, ci);
            end
            DP_B_DIV:
            begin
                div_start = 1'b1;
                div_num   = acc_reg;
                div_den   = rdata_reg;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Matrix memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            matrix_mem[waddr] <= wdata;
        end
        rdata_reg <= matrix_mem[raddr];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (cmd.op)
            DP_LOAD:
            begin
                if (operation && row_ok)
                begin
                    rhs_reg[IW'(row)] <= value;
                end
            end
            DP_PV_FIRST:
            begin
                cur_piv_reg <= ro_sel;
            end
            DP_PV_FIRSTW:
            begin
                cur_val_reg <= rdata_reg;
            end
            DP_PV_RD, DP_E_RD:
            begin
                pj_reg <= ro_sel;
            end
            DP_PV_CMP:
            begin
                if (mag(rdata_reg) > mag(cur_val_reg))
                begin
                    cur_piv_reg <= pj_reg;
                    cur_val_reg <= rdata_reg;
                end
            end
            DP_F_INIT:
            begin
                pi_reg  <= ro_sel;
                acc_reg <= rhs_reg[ro_sel];
            end
            DP_B_INIT:
            begin
                pi_reg  <= ro_sel;
                acc_reg <= wv_sel;
            end
            DP_S_ACC:
            begin
                acc_reg <= sub_sat(acc_reg, prod_rnd);
            end
            DP_F_WR:
            begin
                wv_reg[ci] <= acc_reg;
            end
            DP_B_WR:
            begin
                wv_reg[ci] <= div_quo;
            end
            default:
            begin
            end
        endcase
    end

    // Row order and pivot error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < DIM; n++)
            begin
                ro_reg[n] <= IW'(n);
            end
            err_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                DP_INIT:
                begin
                    for (int n = 0; n < DIM; n++)
                    begin
                        ro_reg[n] <= IW'(n);
                    end
                    err_reg <= 1'b0;
                end
                DP_PV_CMP:
                begin
                    if (mag(rdata_reg) > mag(cur_val_reg))
                    begin
                        ro_reg[cj] <= cur_piv_reg;
                    end
                end
                DP_PV_END:
                begin
                    ro_reg[ci] <= cur_piv_reg;
                    if (cur_val_reg == '0)
                    begin
                        err_reg <= 1'b1;
                    end
                end
                default:
                begin
                    err_reg <= err_reg;
                end
            endcase
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_OUT)
        begin
            out_index_reg <= 3'(cmd.i);
            out_sol_reg   <= wv_sel;
            out_final_reg <= (cmd.i == CNT_W'(DIM - 1));
            out_zero_reg  <= err_reg;
        end
    end

    plu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.index      = out_index_reg;
    assign out_ch.solution   = out_sol_reg;
    assign out_ch.final_res  = out_final_reg;
    assign out_ch.zero_pivot = out_zero_reg;

    assign sts.div_busy = div_busy;
    assign sts.piv_zero = (cur_val_reg == '0);
    assign sts.out_full = out_valid_reg;

endmodule

// File: sv/plu_ctrl.sv
// ----------------------------------------------------------------------------
// plu_ctrl
// Sequencer: walks load, pivot scan, elimination, forward and back
// substitution and result emission, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module plu_ctrl
    import plu_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_start_req,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [CNT_W-1:0] DIM_C  = CNT_W'(DIM);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(DIM - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] i_inc, j_inc, k_inc;

    assign i_inc = i_reg + 1'b1;
    assign j_inc = j_reg + 1'b1;
    assign k_inc = k_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_start_req)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                i_next     = '0;
                state_next = S_PV_FIRST;
            end
            S_PV_FIRST:
            begin
                j_next     = i_inc;
                state_next = S_PV_FIRSTW;
            end
            S_PV_FIRSTW:
            begin
                state_next = (j_reg == DIM_C) ? S_PV_END : S_PV_RD;
            end
            S_PV_RD:
            begin
                state_next = S_PV_CMP;
            end
            S_PV_CMP:
            begin
                j_next     = j_inc;
                state_next = (j_inc == DIM_C) ? S_PV_END : S_PV_RD;
            end
            S_PV_END:
            begin
                j_next = i_inc;
                if (i_inc == DIM_C)
                begin
                    i_next     = '0;
                    state_next = S_F_INIT;
                end
                else
                begin
                    state_next = sts.piv_zero ? S_Z_WR : S_E_RD;
                end
            end
            S_Z_WR, S_E_WM:
            begin
                j_next = j_inc;
                if (j_inc == DIM_C)
                begin
                    if (i_inc == DIM_C)
                    begin
                        i_next     = '0;
                        state_next = S_F_INIT;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_PV_FIRST;
                    end
                end
                else
                begin
                    state_next = (state_reg == S_Z_WR) ? S_Z_WR : S_E_RD;
                end
            end
            S_E_RD:
            begin
                state_next = S_E_DIV;
            end
            S_E_DIV:
            begin
                state_next = S_E_WAIT;
            end
            S_E_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    k_next     = i_inc;
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                state_next = S_K_MUL;
            end
            S_K_MUL:
            begin
                state_next = S_K_WR;
            end
            S_K_WR:
            begin
                k_next     = k_inc;
                state_next = (k_inc == DIM_C) ? S_E_WM : S_K_RD;
            end
            S_F_INIT:
            begin
                j_next     = '0;
                state_next = (i_reg == '0) ? S_F_WR : S_F_RD;
            end
            S_F_RD:
            begin
                state_next = S_F_MUL;
            end
            S_F_MUL:
            begin
                state_next = S_F_ACC;
            end
            S_F_ACC:
            begin
                j_next     = j_inc;
                state_next = (j_inc == i_reg) ? S_F_WR : S_F_RD;
            end
            S_F_WR:
            begin
                if (i_inc == DIM_C)
                begin
                    i_next     = LAST_C;
                    state_next = S_B_INIT;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_F_INIT;
                end
            end
            S_B_INIT:
            begin
                j_next     = i_inc;
                state_next = (i_inc == DIM_C) ? S_B_DIAG : S_B_RD;
            end
            S_B_RD:
            begin
                state_next = S_B_MUL;
            end
            S_B_MUL:
            begin
                state_next = S_B_ACC;
            end
            S_B_ACC:
            begin
                j_next     = j_inc;
                state_next = (j_inc == DIM_C) ? S_B_DIAG : S_B_RD;
            end
            S_B_DIAG:
            begin
                state_next = S_B_DIV;
            end
            S_B_DIV:
            begin
                state_next = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (i_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_B_INIT;
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (!sts.out_full)
                begin
                    if (i_inc == DIM_C)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_OUT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd.op   = DP_NOP;
        cmd.i    = i_reg;
        cmd.j    = j_reg;
        cmd.k    = k_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? DP_LOAD : DP_NOP;
            end
            S_INIT:      cmd.op = DP_INIT;
            S_PV_FIRST:  cmd.op = DP_PV_FIRST;
            S_PV_FIRSTW: cmd.op = DP_PV_FIRSTW;
            S_PV_RD:     cmd.op = DP_PV_RD;
            S_PV_CMP:    cmd.op = DP_PV_CMP;
            S_PV_END:    cmd.op = DP_PV_END;
            S_Z_WR:      cmd.op = DP_Z_WR;
            S_E_RD:      cmd.op = DP_E_RD;
            S_E_DIV:     cmd.op = DP_E_DIV;
            S_K_RD:      cmd.op = DP_K_RD;
            S_K_MUL:     cmd.op = DP_K_MUL;
            S_K_WR:      cmd.op = DP_K_WR;
            S_E_WM:      cmd.op = DP_E_WM;
            S_F_INIT:    cmd.op = DP_F_INIT;
            S_F_RD:      cmd.op = DP_S_RD;
            S_B_RD:      cmd.op = DP_S_RD;
            S_F_MUL:     cmd.op = DP_S_MUL;
            S_B_MUL:     cmd.op = DP_S_MUL;
            S_F_ACC:     cmd.op = DP_S_ACC;
            S_B_ACC:     cmd.op = DP_S_ACC;
            S_F_WR:      cmd.op = DP_F_WR;
            S_B_INIT:    cmd.op = DP_B_INIT;
            S_B_DIAG:    cmd.op = DP_B_DIAG;
            S_B_DIV:     cmd.op = DP_B_DIV;
            S_B_WAIT:    cmd.op = sts.div_busy ? DP_NOP : DP_B_WR;
            S_OUT:       cmd.op = DP_OUT;
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

// File: sv/pivoted_lu_linear_solver.sv
// ----------------------------------------------------------------------------
// pivoted_lu_linear_solver
// Loads A and b, factors A in place by LU with row pivoting, then solves
// Ax = b by forward and back substitution and streams x out in index order.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | per item
//  ---------+-----+------------------------------------------+-------------
//  in_ch    | in  | operation, row, col, value, start_req    | one load
//  out_ch   | out | index, solution, final_res, zero_pivot   | DIM results
//
// After the item with start_req the run time of the block is set by the shared
// divider (DIM*(DIM+1)/2 divisions) and the multiply-subtract steps on the
// single memory read port. No load is taken until all DIM results are out;
// each result holds while out_ch.ready is low.
// Reset clears the sequencer, row order and pivot error; stores need loads.
module pivoted_lu_linear_solver
    import plu_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    plu_item_if.sink     in_ch,
    plu_result_if.source out_ch
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    plu_ctrl #(.DIM(DIM)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_start_req (in_ch.start_req),
        .in_ready     (in_ch.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    plu_dpath #(.DIM(DIM)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (in_ch.operation),
        .row       (in_ch.row),
        .col       (in_ch.col),
        .value     (in_ch.value),
        .out_ch    (out_ch)
    );

endmodule

// File: sv/plu_checker.sv
// ----------------------------------------------------------------------------
// plu_checker
// Port-level checks on load and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "pivoted_lu_linear_solver_macros.svh"

module plu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_start_req,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_final,
    input logic [31:0] out_solution
);

    // Stalled result holds
    `PLU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_solution))
    // No load while a result is pending
    `PLU_ASSERT_IMP(a_no_load_out, out_valid, !in_ready)
    // Start closes the load window
    `PLU_ASSERT_NXT(a_start_busy, in_valid && in_ready && in_start_req, !in_ready)
    // More results follow a non-final one
    `PLU_ASSERT_NXT(a_mid_busy, out_valid && out_ready && !out_final, !in_ready)
    // Final result ends the stream
    `PLU_ASSERT_NXT(a_final_ends, out_valid && out_ready && out_final, !out_valid)

endmodule

bind pivoted_lu_linear_solver plu_checker u_plu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_start_req (in_ch.start_req),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_final    (out_ch.final_res),
    .out_solution (out_ch.solution)
);

// File: dv/pivoted_lu_linear_solver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pivoted_lu_linear_solver_tb
// Loads full and partial systems into the solver and starts solves. Each
// solution is predicted in a shadow LU model with the same Q15.16 rounding
// and saturation. Returned elements are checked in order while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module pivoted_lu_linear_solver_tb;
    import plu_pkg::*;

    localparam int N          = DIM_DEF;
    localparam int IDLE_LIMIT = 40000;
    localparam bit OP_MATRIX  = 1'b0;
    localparam bit OP_RHS     = 1'b1;

    typedef struct {
        bit                 operation;
        bit [2:0]           row;
        bit [2:0]           col;
        logic signed [31:0] value;
        bit                 start_req;
        bit                 hold;
    } load_req_t;

    typedef struct {
        bit [2:0]           index;
        logic signed [31:0] solution;
        bit                 final_res;
        bit                 zero_pivot;
    } x_elem_t;

    logic clk;
    logic rst_n;

    plu_item_if   in_ch();
    plu_result_if out_ch();

    pivoted_lu_linear_solver #(.DIM(N)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the solver state
    logic signed [31:0] a_shadow [N*N];
    logic signed [31:0] b_shadow [N];
    int                 perm     [N];
    logic signed [31:0] xw       [N];
    bit                 singular;

    load_req_t pend_q[$];
    x_elem_t   solution_q[$];
    load_req_t cur_req;
    int        errors;
    int        solves_done;
    int        issued_cnt;
    int        received_cnt;
    int        send_idle;
    int        recv_stall;
    int        quiet_cycles;

    always #2 clk = ~clk;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Round half up: floor((a*b + 0.5 lsb) / 2^16)
    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = a * b + 32768;
        return sat32(p >>> 16);
    endfunction

    function automatic longint q_div(longint a, longint b);
        if (b == 0)
            return 0;
        return sat32((a * 65536) / b);
    endfunction

    function automatic longint q_abs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint a_at(int r, int c);
        return a_shadow[perm[r]*N + c];
    endfunction

    function automatic void a_put(int r, int c, longint v);
        a_shadow[perm[r]*N + c] = 32'(sat32(v));
    endfunction

    // Factor in place, substitute, and queue the expected solution
    task automatic lu_solve_predict();
        int       t;
        longint   m;
        longint   acc;
        x_elem_t  e;
        for (int i = 0; i < N; i++)
            perm[i] = i;
        singular = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            for (int j = i + 1; j < N; j++)
            begin
                if (q_abs(a_at(i, i)) < q_abs(a_at(j, i)))
                begin
                    t       = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
            end
            if (a_at(i, i) == 0)
            begin
                singular = 1'b1;
                for (int j = i + 1; j < N; j++)
                    a_put(j, i, 0);
            end
            else
            begin
                for (int j = i + 1; j < N; j++)
                begin
                    m = q_div(a_at(j, i), a_at(i, i));
                    for (int k = i + 1; k < N; k++)
                        a_put(j, k, a_at(j, k) - q_mul(m, a_at(i, k)));
                    a_put(j, i, m);
                end
            end
        end
        for (int i = 0; i < N; i++)
        begin
            acc = b_shadow[perm[i]];
            for (int j = 0; j < i; j++)
                acc = sat32(acc - q_mul(a_at(i, j), xw[j]));
            xw[i] = 32'(acc);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            acc = xw[i];
            for (int j = i + 1; j < N; j++)
                acc = sat32(acc - q_mul(a_at(i, j), xw[j]));
            xw[i] = 32'(q_div(acc, a_at(i, i)));
        end
        for (int i = 0; i < N; i++)
        begin
            e.index      = 3'(i);
            e.solution   = xw[i];
            e.final_res  = (i == N - 1);
            e.zero_pivot = singular;
            solution_q.push_back(e);
        end
    endtask

    task automatic apply_load(load_req_t r);
        if (r.operation == OP_MATRIX)
            a_shadow[r.row*N + r.col] = r.value;
        else
            b_shadow[r.row] = r.value;
        if (r.start_req)
            lu_solve_predict();
    endtask

    task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch: %s at x[%0d]: got %h, want %h", what, idx, got, want);
    endtask

    task automatic push_load(bit op, int r, int c, logic signed [31:0] v, bit st,
                             bit hold);
        load_req_t q;
        q.operation = op;
        q.row       = 3'(r);
        q.col       = 3'(c);
        q.value     = v;
        q.start_req = st;
        q.hold      = hold;
        pend_q.push_back(q);
    endtask

    // Mostly moderate values within +-4.0 (diagonal ones shifted up by 8.0), some zeros and full-range words
    function automatic logic signed [31:0] pick_value(bit diag);
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = 0;
            default:
            begin
                v = $urandom_range(0, 1 << 19) - (1 << 18);
                if (diag)
                    v = v + (8 << 16);
            end
        endcase
        return v;
    endfunction

    // Driver: present pending requests, feed the shadow model on accept
    always @(posedge clk or negedge rst_n)
    begin
        bit vld;
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.operation <= 1'b0;
            in_ch.row       <= '0;
            in_ch.col       <= '0;
            in_ch.value     <= '0;
            in_ch.start_req <= 1'b0;
            issued_cnt      = 0;
            solves_done     = 0;
        end
        else
        begin
            vld = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                apply_load(cur_req);
                if (cur_req.start_req)
                begin
                    issued_cnt += N;
                    solves_done++;
                end
                vld = 1'b0;
            end
            case (solves_done % 4)
                0: send_idle = 0;
                1: send_idle = 66;
                2: send_idle = 0;
                default: send_idle = 32;
            endcase
            if (!vld && pend_q.size() > 0)
            begin
                // hold a marked request until the last solution has drained
                if (!(pend_q[0].hold && received_cnt != issued_cnt)
                    && $urandom_range(0, 99) >= send_idle)
                begin
                    cur_req          = pend_q.pop_front();
                    in_ch.operation <= cur_req.operation;
                    in_ch.row       <= cur_req.row;
                    in_ch.col       <= cur_req.col;
                    in_ch.value     <= cur_req.value;
                    in_ch.start_req <= cur_req.start_req;
                    vld              = 1'b1;
                end
            end
            in_ch.valid <= vld;
        end
    end

    // Monitor: check each solution element against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        x_elem_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            received_cnt <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                received_cnt <= received_cnt + 1;
                if (solution_q.size() == 0)
                begin
                    errors++;
                    $display("mismatch: unexpected solution element %0d", out_ch.index);
                end
                else
                begin
                    e = solution_q.pop_front();
                    if (out_ch.index !== e.index)
                        report("index", e.index, out_ch.index, e.index);
                    if (out_ch.solution !== e.solution)
                        report("solution", e.index, out_ch.solution, e.solution);
                    if (out_ch.final_res !== e.final_res)
                        report("final_res", e.index, out_ch.final_res, e.final_res);
                    if (out_ch.zero_pivot !== e.zero_pivot)
                        report("zero_pivot", e.index, out_ch.zero_pivot, e.zero_pivot);
                end
            end
            case (solves_done % 4)
                0: recv_stall = 0;
                1: recv_stall = 0;
                2: recv_stall = 66;
                default: recv_stall = 32;
            endcase
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int r;
        int c;
        clk          = 1'b0;
        rst_n        = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        in_ch.valid  = 1'b0;
        out_ch.ready = 1'b0;

        // Full first load: every entry written before any solve
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                push_load(OP_MATRIX, i, j, pick_value(i == j), 1'b0, 1'b0);
        for (int i = 0; i < N; i++)
            push_load(OP_RHS, i, 0, pick_value(1'b0), i == N - 1, 1'b0);

        // Extreme values, matrix start and rhs start
        push_load(OP_MATRIX, 0, 0, 32'sh7fffffff, 1'b0, 1'b0);
        push_load(OP_MATRIX, 7, 7, 32'sh80000000, 1'b0, 1'b0);
        push_load(OP_RHS, 0, 0, 32'sh80000000, 1'b0, 1'b0);
        push_load(OP_RHS, 7, 0, 32'sh7fffffff, 1'b0, 1'b0);
        push_load(OP_MATRIX, 3, 5, 32'shffffffff, 1'b1, 1'b0);
        // Reuse of the factored store with no reload
        push_load(OP_RHS, 2, 7, 32'sh00010000, 1'b1, 1'b1);
        // Whole first column zero: zero pivot
        for (int i = 0; i < N; i++)
            push_load(OP_MATRIX, i, 0, 0, i == N - 1, i == 0);
        // Bigger entry below the diagonal forces a row swap
        push_load(OP_MATRIX, 0, 0, 32'sh00010000, 1'b0, 1'b0);
        push_load(OP_MATRIX, 5, 0, 32'sh00100000, 1'b1, 1'b0);

        // Random rounds of partial reloads, each ending with a start
        while (pend_q.size() < 310)
        begin
            n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, N - 1);
                c = $urandom_range(0, N - 1);
                if ($urandom_range(0, 4) == 0)
                    push_load(OP_RHS, r, c, pick_value(1'b0), i == n - 1,
                              i == 0 && $urandom_range(0, 3) == 0);
                else
                    push_load(OP_MATRIX, r, c, pick_value(r == c), i == n - 1,
                              i == 0 && $urandom_range(0, 3) == 0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain stimulus and expectations, then allow a short tail
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_ch.valid || solution_q.size() != 0);
        repeat (200) @(negedge clk);

        if (solution_q.size() != 0)
        begin
            errors++;
            $display("mismatch: %0d solution elements never returned", solution_q.size());
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
